@@ design/quantized_global_average_pool_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Quantized global average pool unit: assertion macros
// Shared property templates for the checker of the pooling unit.
// ----------------------------------------------------------------------------
`ifndef QUANTIZED_GLOBAL_AVERAGE_POOL_UNIT_DEFINES_SVH
`define QUANTIZED_GLOBAL_AVERAGE_POOL_UNIT_DEFINES_SVH

// Implication in the same cycle, disabled while reset is asserted.
`define QGAP_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error(msg);

// Implication into the next cycle, disabled while reset is asserted.
`define QGAP_ASSERT_NXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error(msg);

// Implication into the next cycle that is also checked during reset.
`define QGAP_ASSERT_NXT_RST(lbl, clk, pre, post, msg) \
    lbl: assert property (@(posedge clk) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ design/qgap_pkg.sv @@
// ----------------------------------------------------------------------------
// Quantized global average pool package
// Widths, register indexes and shared types of the pooling unit.
// ----------------------------------------------------------------------------
`default_nettype none

package qgap_pkg;

    localparam int LANES    = 8;
    localparam int MAX_ROWS = 7;

    localparam int BYTE_W   = 8;
    localparam int ROW_W    = LANES * BYTE_W;
    localparam int COUNT_W  = $clog2(LANES + 1);

    localparam int ROWS_W   = $clog2(MAX_ROWS + 1);
    localparam int BIAS_W   = 25;
    localparam int SCALE_W  = 32;
    localparam int FRAC_W   = 24;
    localparam int ZP_W     = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // The row sum of up to seven bytes stays well below the bias range,
    // so one extra bit holds bias plus rows.
    localparam int SUM_W  = BIAS_W + 1;
    localparam int MAG_W  = SUM_W - 1;
    localparam int PROD_W = MAG_W + SCALE_W;
    localparam int Q_W    = PROD_W - FRAC_W;
    localparam int V_W    = 16;

    localparam int LANE_STAGES = 4;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_USED  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BIAS       = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_SCALE      = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_POINT = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_LOW  = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_HIGH = CFG_IDX_W'(5);

    typedef struct packed {
        logic [ROWS_W-1:0]  rows_used;
        logic [BIAS_W-1:0]  bias;
        logic [SCALE_W-1:0] scale;
        logic [ZP_W-1:0]    zero_point;
        logic [BYTE_W-1:0]  clamp_low;
        logic [BYTE_W-1:0]  clamp_high;
    } t_cfg;

    typedef struct packed {
        logic [LANE_STAGES-1:0] en;
    } t_pipe_ctrl;

    typedef logic [MAX_ROWS-1:0][BYTE_W-1:0] t_lane_rows;

endpackage

`default_nettype wire

@@ design/qgap_if.sv @@
// ----------------------------------------------------------------------------
// Quantized global average pool channel interfaces
// Valid/ready channels for input beats, result beats and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface qgap_in_if;
    import qgap_pkg::*;

    logic               valid;
    logic               ready;
    logic [ROW_W-1:0]   row0_bytes;
    logic [ROW_W-1:0]   row1_bytes;
    logic [ROW_W-1:0]   row2_bytes;
    logic [ROW_W-1:0]   row3_bytes;
    logic [ROW_W-1:0]   row4_bytes;
    logic [ROW_W-1:0]   row5_bytes;
    logic [ROW_W-1:0]   row6_bytes;
    logic [COUNT_W-1:0] lane_count;

    modport source (
        output valid, row0_bytes, row1_bytes, row2_bytes, row3_bytes,
               row4_bytes, row5_bytes, row6_bytes, lane_count,
        input  ready
    );
    modport sink (
        input  valid, row0_bytes, row1_bytes, row2_bytes, row3_bytes,
               row4_bytes, row5_bytes, row6_bytes, lane_count,
        output ready
    );
endinterface

interface qgap_out_if;
    import qgap_pkg::*;

    logic               valid;
    logic               ready;
    logic [ROW_W-1:0]   pooled_bytes;
    logic [COUNT_W-1:0] pooled_count;

    modport source (output valid, pooled_bytes, pooled_count, input ready);
    modport sink (input valid, pooled_bytes, pooled_count, output ready);
endinterface

interface qgap_cfg_if;
    import qgap_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ design/qgap_lane.sv @@
// ----------------------------------------------------------------------------
// Quantized global average pool lane
// Four-stage datapath for one channel: row sum, scale, round, requantize.
// ----------------------------------------------------------------------------
`default_nettype none

module qgap_lane (
    input  wire logic                i_clk,
    input  wire qgap_pkg::t_pipe_ctrl i_ctrl,
    input  wire qgap_pkg::t_cfg      i_cfg,
    input  wire qgap_pkg::t_lane_rows i_rows,
    output logic [qgap_pkg::BYTE_W-1:0] o_byte
);
    import qgap_pkg::*;

    localparam logic [Q_W-1:0]      Q_POS_MAX = Q_W'(32767);
    localparam logic [Q_W-1:0]      Q_NEG_MAX = Q_W'(32768);
    localparam logic [FRAC_W-1:0]   HALF      = {1'b1, {(FRAC_W-1){1'b0}}};
    localparam logic [V_W-1:0]      V_POS_MAX = {1'b0, {(V_W-1){1'b1}}};
    localparam logic [V_W-1:0]      V_NEG_MAX = {1'b1, {(V_W-1){1'b0}}};

    logic [SUM_W-1:0]  n_sum;
    logic [SUM_W-1:0]  n_abs;
    logic              r_neg;
    logic [MAG_W-1:0]  r_mag;
    logic              r_neg1;
    logic [PROD_W-1:0] r_prod;
    logic [Q_W-1:0]    n_q;
    logic [V_W-1:0]    n_v;
    logic [V_W-1:0]    r_v;
    logic [V_W:0]      n_zs;
    logic [BYTE_W-1:0] n_byte;
    logic [BYTE_W-1:0] r_byte;

    always_comb begin
        n_sum = {{(SUM_W-BIAS_W){i_cfg.bias[BIAS_W-1]}}, i_cfg.bias};
        for (int r = 0; r < MAX_ROWS; r++) begin
            if (r == 0 || ROWS_W'(r) < i_cfg.rows_used) begin
                n_sum = n_sum + {{(SUM_W-BYTE_W){1'b0}}, i_rows[r]};
            end
        end
        n_abs = n_sum[SUM_W-1] ? (~n_sum + SUM_W'(1)) : n_sum;
    end

    always_comb begin
        n_q = r_prod[PROD_W-1:FRAC_W];
        if (r_prod[FRAC_W-1:0] > HALF || (r_prod[FRAC_W-1:0] == HALF && n_q[0])) begin
            n_q = n_q + Q_W'(1);
        end
        if (r_neg1) begin
            n_v = (n_q > Q_NEG_MAX) ? V_NEG_MAX : V_W'(~n_q[V_W-1:0] + V_W'(1));
        end else begin
            n_v = (n_q > Q_POS_MAX) ? V_POS_MAX : n_q[V_W-1:0];
        end
    end

    always_comb begin
        n_zs = {r_v[V_W-1], r_v} + {{(V_W+1-ZP_W){1'b0}}, i_cfg.zero_point};
        if (n_zs[V_W]) begin
            n_byte = '0;
        end else if (n_zs[V_W-1:BYTE_W] != '0) begin
            n_byte = '1;
        end else begin
            n_byte = n_zs[BYTE_W-1:0];
        end
        if (n_byte > i_cfg.clamp_high) begin
            n_byte = i_cfg.clamp_high;
        end
        if (n_byte < i_cfg.clamp_low) begin
            n_byte = i_cfg.clamp_low;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en[0]) begin
            r_neg <= n_sum[SUM_W-1];
            r_mag <= n_abs[MAG_W-1:0];
        end
        if (i_ctrl.en[1]) begin
            r_neg1 <= r_neg;
            r_prod <= PROD_W'(r_mag) * PROD_W'(i_cfg.scale);
        end
        if (i_ctrl.en[2]) begin
            r_v <= n_v;
        end
        if (i_ctrl.en[3]) begin
            r_byte <= n_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

`default_nettype wire

@@ design/qgap_merge.sv @@
// ----------------------------------------------------------------------------
// Quantized global average pool merge stage
// Pipeline flow control, lane count tracking and the packed output register.
// ----------------------------------------------------------------------------
`default_nettype none

module qgap_merge (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [qgap_pkg::COUNT_W-1:0]      i_lane_count,
    input  wire logic [qgap_pkg::LANES-1:0][qgap_pkg::BYTE_W-1:0] i_lane_bytes,
    output qgap_pkg::t_pipe_ctrl                   o_ctrl,
    qgap_out_if.source                             o_out
);
    import qgap_pkg::*;

    logic [LANE_STAGES:0]                n_en;
    logic [LANE_STAGES-1:0]              r_vld;
    logic [LANE_STAGES-1:0][COUNT_W-1:0] r_cnt;
    logic [COUNT_W-1:0]                  n_cnt_in;
    logic                                r_out_vld;
    logic [ROW_W-1:0]                    r_out_bytes;
    logic [COUNT_W-1:0]                  r_out_cnt;
    logic [ROW_W-1:0]                    n_packed;

    always_comb begin
        n_en[LANE_STAGES] = !r_out_vld || o_out.ready;
        for (int k = LANE_STAGES - 1; k >= 0; k--) begin
            n_en[k] = !r_vld[k] || n_en[k+1];
        end
    end

    assign n_cnt_in = (i_lane_count > COUNT_W'(LANES)) ? COUNT_W'(LANES) : i_lane_count;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_packed[l*BYTE_W +: BYTE_W] = (COUNT_W'(l) < r_cnt[LANE_STAGES-1])
                                         ? i_lane_bytes[l] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (n_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < LANE_STAGES; k++) begin
                if (n_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            if (n_en[LANE_STAGES]) begin
                r_out_vld <= r_vld[LANE_STAGES-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en[0]) begin
            r_cnt[0] <= n_cnt_in;
        end
        for (int k = 1; k < LANE_STAGES; k++) begin
            if (n_en[k]) begin
                r_cnt[k] <= r_cnt[k-1];
            end
        end
        if (n_en[LANE_STAGES]) begin
            r_out_bytes <= n_packed;
            r_out_cnt   <= r_cnt[LANE_STAGES-1];
        end
    end

    assign o_in_ready         = n_en[0];
    assign o_ctrl.en          = n_en[LANE_STAGES-1:0];
    assign o_out.valid        = r_out_vld;
    assign o_out.pooled_bytes = r_out_bytes;
    assign o_out.pooled_count = r_out_cnt;

endmodule

`default_nettype wire

@@ design/quantized_global_average_pool_unit.sv @@
// ----------------------------------------------------------------------------
// Quantized global average pool unit
// Eight-lane uint8 pooling with bias, Q8.24 scaling and output clamping.
// ----------------------------------------------------------------------------
// Each input beat carries one byte per channel from each of seven rows and
// a count of valid channels. The unit sums the rows in use per channel, adds
// the bias, scales by the Q8.24 factor with round-half-even, requantizes to
// uint8 and clamps. One result beat leaves for every input beat, in order.
// A result beat leaves once an accepted input beat has passed through the
// four register stages in every lane, the multiply among them, and the
// packed output register in the merge stage. The pipeline takes one beat per
// cycle when not full; a beat may enter while the output register still waits.
// When the receiver stalls, the stages fill one by one and input ready
// falls once every stage holds a beat; nothing is dropped.
// Registers are written through the configuration channel, which is always
// ready; writes belong to idle periods. Reset is synchronous and active low,
// empties the pipeline and restores the register defaults at once.
// ----------------------------------------------------------------------------
`default_nettype none

module quantized_global_average_pool_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    qgap_in_if.sink    i_in,
    qgap_out_if.source o_out,
    qgap_cfg_if.sink   i_cfg
);
    import qgap_pkg::*;

    t_cfg                           r_cfg;
    t_pipe_ctrl                     w_ctrl;
    logic                           w_in_ready;
    logic [MAX_ROWS-1:0][ROW_W-1:0] w_row;
    logic [LANES-1:0][BYTE_W-1:0]   w_lane_bytes;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rows_used  <= ROWS_W'(1);
            r_cfg.bias       <= '0;
            r_cfg.scale      <= SCALE_W'(1) << FRAC_W;
            r_cfg.zero_point <= '0;
            r_cfg.clamp_low  <= '0;
            r_cfg.clamp_high <= '1;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_ROWS_USED:  r_cfg.rows_used  <= i_cfg.data[ROWS_W-1:0];
                REG_BIAS:       r_cfg.bias       <= i_cfg.data[BIAS_W-1:0];
                REG_SCALE:      r_cfg.scale      <= i_cfg.data[SCALE_W-1:0];
                REG_ZERO_POINT: r_cfg.zero_point <= i_cfg.data[ZP_W-1:0];
                REG_CLAMP_LOW:  r_cfg.clamp_low  <= i_cfg.data[BYTE_W-1:0];
                REG_CLAMP_HIGH: r_cfg.clamp_high <= i_cfg.data[BYTE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_row[0] = i_in.row0_bytes;
    assign w_row[1] = i_in.row1_bytes;
    assign w_row[2] = i_in.row2_bytes;
    assign w_row[3] = i_in.row3_bytes;
    assign w_row[4] = i_in.row4_bytes;
    assign w_row[5] = i_in.row5_bytes;
    assign w_row[6] = i_in.row6_bytes;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        t_lane_rows w_rows;

        for (genvar r = 0; r < MAX_ROWS; r++) begin : g_row
            assign w_rows[r] = w_row[r][l*BYTE_W +: BYTE_W];
        end

        qgap_lane u_lane (
            .i_clk  (i_clk),
            .i_ctrl (w_ctrl),
            .i_cfg  (r_cfg),
            .i_rows (w_rows),
            .o_byte (w_lane_bytes[l])
        );
    end

    qgap_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .o_in_ready   (w_in_ready),
        .i_lane_count (i_in.lane_count),
        .i_lane_bytes (w_lane_bytes),
        .o_ctrl       (w_ctrl),
        .o_out        (o_out)
    );

    assign i_in.ready = w_in_ready;

endmodule

`default_nettype wire

@@ design/qgap_checker.sv @@
// ----------------------------------------------------------------------------
// Quantized global average pool checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "quantized_global_average_pool_unit_defines.svh"

module qgap_checker (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_out_valid,
    input  wire logic                         i_out_ready,
    input  wire logic [qgap_pkg::ROW_W-1:0]   i_out_bytes,
    input  wire logic [qgap_pkg::COUNT_W-1:0] i_out_count
);
    import qgap_pkg::*;

    `QGAP_ASSERT_NXT_RST(a_reset_empties, i_clk, !i_rst_n, !i_out_valid, "result beat right after reset")
    `QGAP_ASSERT_NXT(a_stall_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_bytes) && $stable(i_out_count), "stalled result beat changed")
    `QGAP_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, i_out_valid, i_out_count <= COUNT_W'(LANES), "result count above lane total")
    `QGAP_ASSERT_IMP(a_empty_zero, i_clk, i_rst_n, i_out_valid && i_out_count == '0, i_out_bytes == '0, "empty result beat carries data")

endmodule

bind quantized_global_average_pool_unit qgap_checker u_qgap_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_bytes (o_out.pooled_bytes),
    .i_out_count (o_out.pooled_count)
);

`default_nettype wire

@@ verif/quantized_global_average_pool_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Quantized global average pool unit testbench
// Streams eight-lane input beats through the pooling unit under several
// register settings. Each accepted beat is scored against a behavioral model
// of the bias, Q8.24 scaling, round-half-even, requantize and clamp path.
// Both channels idle at random, and results are checked in order.
// ----------------------------------------------------------------------------

module quantized_global_average_pool_unit_tb;
    import qgap_pkg::*;

    localparam int LIMIT_CYCLES = 100000;
    localparam int TAIL_CYCLES  = 20;
    localparam int CALM_FROM    = 500;
    localparam int CALM_TO      = 1000;
    localparam int REPORT_MAX   = 10;
    localparam int PHASE_BEATS  = 150;
    localparam int RAND_PHASES  = 8;

    localparam longint I16_MAX   = 32767;
    localparam longint I16_MIN   = -32768;
    localparam longint UINT8_MAX = 255;
    localparam logic [FRAC_W-1:0] HALF_LSB = FRAC_W'(1) << (FRAC_W - 1);

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = REG_CLAMP_HIGH + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = '1;

    typedef struct packed {
        logic [MAX_ROWS-1:0][ROW_W-1:0] rows;
        logic [COUNT_W-1:0]             count;
    } t_pool_beat;

    typedef struct packed {
        logic [ROW_W-1:0]   bytes;
        logic [COUNT_W-1:0] count;
    } t_pool_result;

    typedef enum logic [1:0] {JOB_BEAT, JOB_REG, JOB_DRAIN} t_job_kind;

    typedef struct {
        t_job_kind             kind;
        t_pool_beat            beat;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_pool_job;

    logic i_clk;
    logic i_rst_n;

    qgap_in_if  in_if();
    qgap_out_if out_if();
    qgap_cfg_if cfg_if();

    quantized_global_average_pool_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source),
        .i_cfg   (cfg_if.sink)
    );

    t_pool_job    pool_job_q[$];
    t_pool_result pooled_expect_q[$];
    t_pool_beat   held_beat;
    t_cfg         pool_cfg;
    int           beats_sent;
    int           results_seen;
    int           err_cnt;
    int           cyc;

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
    end

    function automatic bit stall_roll();
        if (cyc >= CALM_FROM && cyc < CALM_TO) begin
            return 1'b0;
        end
        return $urandom_range(0, 99) < 29;
    endfunction

    function automatic void note_error(string msg);
        err_cnt++;
        if (err_cnt <= REPORT_MAX) begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
    endfunction

    function automatic longint sat_i16(longint v);
        if (v > I16_MAX) begin
            return I16_MAX;
        end
        if (v < I16_MIN) begin
            return I16_MIN;
        end
        return v;
    endfunction

    function automatic logic [BYTE_W-1:0] pool_lane(t_pool_beat b, int lane);
        longint acc;
        longint term;
        longint v;
        longint unsigned mag;
        longint unsigned prod;
        longint unsigned q;
        logic [FRAC_W-1:0] frac;
        int r;
        acc = longint'($signed(pool_cfg.bias));
        for (r = 0; r < MAX_ROWS; r++) begin
            if (r == 0 || r < pool_cfg.rows_used) begin
                term = longint'(b.rows[r][lane*BYTE_W +: BYTE_W]);
                acc += term;
            end
        end
        mag = (acc < 0) ? -acc : acc;
        prod = mag * pool_cfg.scale;
        q = prod >> FRAC_W;
        frac = prod[FRAC_W-1:0];
        if (frac > HALF_LSB || (frac == HALF_LSB && q[0])) begin
            q++;
        end
        v = (acc < 0) ? -longint'(q) : longint'(q);
        v = sat_i16(v);
        v = sat_i16(v + longint'(pool_cfg.zero_point));
        if (v < 0) begin
            v = 0;
        end
        if (v > UINT8_MAX) begin
            v = UINT8_MAX;
        end
        if (v > longint'(pool_cfg.clamp_high)) begin
            v = longint'(pool_cfg.clamp_high);
        end
        if (v < longint'(pool_cfg.clamp_low)) begin
            v = longint'(pool_cfg.clamp_low);
        end
        return v[BYTE_W-1:0];
    endfunction

    function automatic t_pool_result pool_beat(t_pool_beat b);
        t_pool_result res;
        logic [COUNT_W-1:0] n;
        int lane;
        n = (b.count > LANES) ? COUNT_W'(LANES) : b.count;
        res.bytes = '0;
        res.count = n;
        for (lane = 0; lane < LANES; lane++) begin
            if (lane < n) begin
                res.bytes[lane*BYTE_W +: BYTE_W] = pool_lane(b, lane);
            end
        end
        return res;
    endfunction

    function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx,
                                            logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_ROWS_USED:  pool_cfg.rows_used  = data[ROWS_W-1:0];
            REG_BIAS:       pool_cfg.bias       = data[BIAS_W-1:0];
            REG_SCALE:      pool_cfg.scale      = data[SCALE_W-1:0];
            REG_ZERO_POINT: pool_cfg.zero_point = data[ZP_W-1:0];
            REG_CLAMP_LOW:  pool_cfg.clamp_low  = data[BYTE_W-1:0];
            REG_CLAMP_HIGH: pool_cfg.clamp_high = data[BYTE_W-1:0];
            default: ;
        endcase
    endfunction

    // Driver: register writes and drain marks wait for an empty pipeline.
    always @(posedge i_clk) begin
        t_pool_job job;
        bit in_nx;
        bit cfg_nx;
        bit pipe_empty;
        if (!i_rst_n) begin
            in_if.valid  <= 1'b0;
            cfg_if.valid <= 1'b0;
            pool_cfg.rows_used  = ROWS_W'(1);
            pool_cfg.bias       = '0;
            pool_cfg.scale      = SCALE_W'(1) << FRAC_W;
            pool_cfg.zero_point = '0;
            pool_cfg.clamp_low  = '0;
            pool_cfg.clamp_high = '1;
        end else begin
            in_nx  = in_if.valid;
            cfg_nx = cfg_if.valid;
            if (in_if.valid && in_if.ready) begin
                pooled_expect_q.push_back(pool_beat(held_beat));
                beats_sent++;
                in_nx = 1'b0;
            end
            if (cfg_if.valid && cfg_if.ready) begin
                apply_reg_write(cfg_if.index, cfg_if.data);
                cfg_nx = 1'b0;
            end
            pipe_empty = (beats_sent == results_seen + (out_if.valid && out_if.ready));
            if (!in_nx && !cfg_nx && pool_job_q.size() != 0) begin
                job = pool_job_q[0];
                case (job.kind)
                    JOB_BEAT: begin
                        if (!stall_roll()) begin
                            void'(pool_job_q.pop_front());
                            held_beat          = job.beat;
                            in_if.row0_bytes  <= job.beat.rows[0];
                            in_if.row1_bytes  <= job.beat.rows[1];
                            in_if.row2_bytes  <= job.beat.rows[2];
                            in_if.row3_bytes  <= job.beat.rows[3];
                            in_if.row4_bytes  <= job.beat.rows[4];
                            in_if.row5_bytes  <= job.beat.rows[5];
                            in_if.row6_bytes  <= job.beat.rows[6];
                            in_if.lane_count  <= job.beat.count;
                            in_nx = 1'b1;
                        end
                    end
                    JOB_REG: begin
                        if (pipe_empty) begin
                            void'(pool_job_q.pop_front());
                            cfg_if.index <= job.idx;
                            cfg_if.data  <= job.data;
                            cfg_nx = 1'b1;
                        end
                    end
                    default: begin
                        if (pipe_empty) begin
                            void'(pool_job_q.pop_front());
                        end
                    end
                endcase
            end
            in_if.valid  <= in_nx;
            cfg_if.valid <= cfg_nx;
        end
    end

    // Monitor: every result beat is scored against the oldest expectation.
    always @(posedge i_clk) begin
        t_pool_result want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                results_seen <= results_seen + 1;
                if (pooled_expect_q.size() == 0) begin
                    note_error($sformatf("unexpected result beat bytes=%h count=%0d",
                                         out_if.pooled_bytes, out_if.pooled_count));
                end else begin
                    want = pooled_expect_q.pop_front();
                    if (out_if.pooled_bytes !== want.bytes) begin
                        note_error($sformatf("beat %0d pooled_bytes: expected %h, got %h",
                                             results_seen, want.bytes,
                                             out_if.pooled_bytes));
                    end
                    if (out_if.pooled_count !== want.count) begin
                        note_error($sformatf("beat %0d pooled_count: expected %0d, got %0d",
                                             results_seen, want.count,
                                             out_if.pooled_count));
                    end
                end
            end
            out_if.ready <= !stall_roll();
        end
    end

    task automatic add_beat(t_pool_beat b);
        t_pool_job job;
        job.kind = JOB_BEAT;
        job.beat = b;
        job.idx  = '0;
        job.data = '0;
        pool_job_q.push_back(job);
    endtask

    task automatic add_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        t_pool_job job;
        job.kind = JOB_REG;
        job.beat = '0;
        job.idx  = idx;
        job.data = data;
        pool_job_q.push_back(job);
    endtask

    task automatic add_drain();
        t_pool_job job;
        job.kind = JOB_DRAIN;
        job.beat = '0;
        job.idx  = '0;
        job.data = '0;
        pool_job_q.push_back(job);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pad_word(logic [CFG_DATA_W-1:0] field, int w);
        return (CFG_DATA_W'($urandom()) << w) | field;
    endfunction

    task automatic add_settings(logic [ROWS_W-1:0] rows, logic [BIAS_W-1:0] bias,
                                logic [SCALE_W-1:0] scale, logic [ZP_W-1:0] zp,
                                logic [BYTE_W-1:0] lo, logic [BYTE_W-1:0] hi);
        add_reg(REG_ROWS_USED, pad_word(CFG_DATA_W'(rows), ROWS_W));
        add_reg(REG_BIAS, pad_word(CFG_DATA_W'(bias), BIAS_W));
        add_reg(REG_SCALE, pad_word(CFG_DATA_W'(scale), SCALE_W));
        add_reg(REG_ZERO_POINT, pad_word(CFG_DATA_W'(zp), ZP_W));
        add_reg(REG_CLAMP_LOW, pad_word(CFG_DATA_W'(lo), BYTE_W));
        add_reg(REG_CLAMP_HIGH, pad_word(CFG_DATA_W'(hi), BYTE_W));
    endtask

    function automatic t_pool_beat fill_beat(logic [ROW_W-1:0] row, logic [COUNT_W-1:0] n);
        t_pool_beat b;
        int r;
        for (r = 0; r < MAX_ROWS; r++) begin
            b.rows[r] = row;
        end
        b.count = n;
        return b;
    endfunction

    function automatic t_pool_beat random_beat();
        t_pool_beat b;
        int r;
        int mode;
        int pick;
        mode = $urandom_range(0, 9);
        for (r = 0; r < MAX_ROWS; r++) begin
            b.rows[r] = {$urandom(), $urandom()};
            if (mode == 0) begin
                b.rows[r] = b.rows[r] | {LANES{8'hE0}};
            end else if (mode == 1) begin
                b.rows[r] = b.rows[r] & {LANES{8'h1F}};
            end
        end
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            b.count = COUNT_W'($urandom_range(0, 15));
        end else if (pick < 5) begin
            b.count = COUNT_W'($urandom_range(1, LANES - 1));
        end else begin
            b.count = COUNT_W'(LANES);
        end
        return b;
    endfunction

    task automatic add_random_settings();
        logic [BIAS_W-1:0]  bias;
        logic [SCALE_W-1:0] scale;
        logic [BYTE_W-1:0]  lo;
        logic [BYTE_W-1:0]  hi;
        if ($urandom_range(0, 3) != 0) begin
            bias = BIAS_W'(int'($urandom_range(0, 4000)) - 2000);
        end else begin
            bias = BIAS_W'($urandom());
        end
        if ($urandom_range(0, 3) != 0) begin
            scale = SCALE_W'($urandom_range(0, 32'h0200_0000));
        end else begin
            scale = SCALE_W'($urandom());
        end
        if ($urandom_range(0, 3) != 0) begin
            lo = BYTE_W'($urandom_range(0, 64));
            hi = BYTE_W'($urandom_range(160, 255));
        end else begin
            lo = BYTE_W'($urandom());
            hi = BYTE_W'($urandom());
        end
        add_settings(ROWS_W'($urandom_range(0, MAX_ROWS)), bias, scale,
                     ZP_W'($urandom()), lo, hi);
        if ($urandom_range(0, 1) == 0) begin
            add_reg(REG_SPARE_FIRST, $urandom());
        end
    endtask

    initial begin
        logic [ROW_W-1:0] ramp;
        t_pool_beat b;
        int p;
        int k;
        bit timed_out;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.row0_bytes = '0;
        in_if.row1_bytes = '0;
        in_if.row2_bytes = '0;
        in_if.row3_bytes = '0;
        in_if.row4_bytes = '0;
        in_if.row5_bytes = '0;
        in_if.row6_bytes = '0;
        in_if.lane_count = '0;
        out_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data = '0;
        beats_sent = 0;
        results_seen = 0;
        err_cnt = 0;
        cyc = 0;
        ramp = 64'h0706_0504_0302_0100;

        // Reset settings: lane count edges and byte extremes.
        add_beat(fill_beat('0, COUNT_W'(LANES)));
        add_beat(fill_beat('1, COUNT_W'(LANES)));
        add_beat(fill_beat(ramp, COUNT_W'(LANES)));
        b = random_beat();
        b.count = '0;
        add_beat(b);
        b = random_beat();
        b.count = '1;
        add_beat(b);
        b = random_beat();
        b.count = COUNT_W'(LANES + 1);
        add_beat(b);
        b = random_beat();
        b.count = COUNT_W'(3);
        add_beat(b);

        // Average over all seven rows.
        add_settings(ROWS_W'(MAX_ROWS), '0, SCALE_W'(2396745), '0, '0, '1);
        add_beat(fill_beat('1, COUNT_W'(LANES)));
        b = fill_beat({LANES{8'h55}}, COUNT_W'(LANES));
        b.rows[1] = {LANES{8'hAA}};
        b.rows[4] = {LANES{8'hAA}};
        add_beat(b);
        add_beat(random_beat());

        // Half scale exposes ties on both sides of zero; zero rows acts as one.
        add_settings('0, '0, SCALE_W'(1) << (FRAC_W - 1), '0, '0, '1);
        add_beat(fill_beat(ramp, COUNT_W'(LANES)));
        add_settings(ROWS_W'(1), BIAS_W'(-8), SCALE_W'(1) << (FRAC_W - 1), '0, '0, '1);
        add_beat(fill_beat(ramp, COUNT_W'(LANES)));

        // Register extremes drive both int16 saturations.
        add_settings(ROWS_W'(MAX_ROWS), {1'b0, {(BIAS_W-1){1'b1}}}, '1, '1, '0, '1);
        add_beat(fill_beat('1, COUNT_W'(LANES)));
        add_beat(fill_beat('0, COUNT_W'(LANES)));
        add_settings(ROWS_W'(MAX_ROWS), {1'b1, {(BIAS_W-1){1'b0}}}, '1, '1, '0, '1);
        add_beat(fill_beat('0, COUNT_W'(LANES)));
        add_beat(random_beat());

        // Zero scale with crossed clamps; writes to unused indexes change nothing.
        add_reg(REG_SPARE_FIRST, '1);
        add_reg(REG_SPARE_LAST, '1);
        add_settings(ROWS_W'(2), '0, '0, ZP_W'(128), BYTE_W'(200), BYTE_W'(50));
        add_beat(random_beat());
        b = random_beat();
        b.count = COUNT_W'(5);
        add_beat(b);
        add_settings(ROWS_W'(3), BIAS_W'(100), SCALE_W'(1) << FRAC_W, '0,
                     BYTE_W'(16), BYTE_W'(235));
        add_beat(random_beat());
        add_beat(fill_beat('1, COUNT_W'(LANES)));

        for (p = 0; p < RAND_PHASES; p++) begin
            add_random_settings();
            for (k = 0; k < PHASE_BEATS; k++) begin
                if (k == PHASE_BEATS / 2) begin
                    add_drain();
                end
                add_beat(random_beat());
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while ((pool_job_q.size() != 0 || in_if.valid || cfg_if.valid
                || beats_sent != results_seen) && cyc < LIMIT_CYCLES) begin
            @(posedge i_clk);
        end
        timed_out = (cyc >= LIMIT_CYCLES);
        if (!timed_out) begin
            repeat (TAIL_CYCLES) @(posedge i_clk);
        end
        if (pooled_expect_q.size() != 0) begin
            note_error($sformatf("%0d expected result beats never arrived",
                                 pooled_expect_q.size()));
        end
        if (err_cnt == 0 && !timed_out) begin
            $display("quantized_global_average_pool_unit_tb: done, clean");
        end else begin
            $display("quantized_global_average_pool_unit_tb: done, errors");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+design
design/qgap_pkg.sv
design/qgap_if.sv
design/qgap_lane.sv
design/qgap_merge.sv
design/quantized_global_average_pool_unit.sv
design/qgap_checker.sv
verif/quantized_global_average_pool_unit_tb.sv
